>>> sv/rrt_pkg.sv
// shared types and codes of the rrt nearest-node and steer block
package rrt_pkg;
   localparam logic [1:0] REQ_PLANT   = 2'd0;
   localparam logic [1:0] REQ_EXTEND  = 2'd1;
   localparam logic [1:0] REQ_APPEND  = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [0:0] REG_STEP  = 1'd0;
   localparam logic [0:0] REG_LIMIT = 1'd1;

   localparam logic [30:0] STEP_RESET  = 31'd65536;
   localparam logic [11:0] LIMIT_RESET = 12'd1500;
endpackage

>>> sv/rrt_nearest_and_steer.sv
// rrt nearest-node search and steer step over a node table in block memory
// plant and append: result valid in the cycle after acceptance; extend: one read per node,
//   then, with the target beyond a step, a 35-step root and two 64-step dividers
// throughput: plant and append one per cycle while results are taken; extend blocks requests
// reset: synchronous active high; clears node count, state and csr registers; memory kept
// a new transaction is accepted only while the result register is empty or being taken
module rrt_nearest_and_steer #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] point_x, [63:32] point_y, [74:64] parent_index, rest zero
   input  logic [79:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [10:0] node_index, [42:11] steered_x, [74:43] steered_y, rest zero
   output logic [79:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_PICK = 4'd2, S_PDATA = 4'd3,
      S_SQR = 4'd4, S_DIVX = 4'd5, S_DIVY = 4'd6, S_OUT = 4'd7, S_WAIT = 4'd8;

   // node memories
   logic [31:0] mem_x [TABLE_DEPTH];
   logic [31:0] mem_y [TABLE_DEPTH];
   logic [10:0] mem_p [TABLE_DEPTH];
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0]   wx, wy, rx, ry;
   logic [10:0]   wp;
   always_ff @(posedge clock) begin
      if (we) begin
         mem_x[waddr] <= wx;
         mem_y[waddr] <= wy;
         mem_p[waddr] <= wp;
      end
      rx <= mem_x[raddr];
      ry <= mem_y[raddr];
   end

   logic [30:0] step_ff;
   logic [11:0] limit_ff;
   logic [3:0]  state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] scan_ff;    // next address issued
   logic          rdv_ff;     // read data valid
   logic [AW-1:0] rdi_ff;     // index of read data
   logic signed [31:0] tx_ff, ty_ff;
   logic [64:0]   best_ff;
   logic [AW-1:0] bidx_ff;
   logic [31:0]   nx_ff, ny_ff;
   logic [34:0]   root_ff, rem_ff;
   logic [69:0]   rad_ff;
   logic [5:0]    it_ff;
   logic [63:0]   num_ff, quo_ff;
   logic [34:0]   drem_ff;
   logic          ovalid_ff;
   logic [10:0]   oidx_ff;
   logic [31:0]   osx_ff, osy_ff;
   logic [1:0]    ost_ff;

   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         rrt_pkg::REG_STEP: csr_prdata = {1'b0, step_ff};
         default:           csr_prdata = {20'd0, limit_ff};
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !(ovalid_ff && !rsp_tready);
   logic acc;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {5'd0, osy_ff, osx_ff, oidx_ff};
   assign rsp_tuser  = ost_ff;

   // squared distance of read data to target
   logic signed [32:0] ddx, ddy;
   logic [32:0] adx, ady;
   logic [64:0] d2;
   assign ddx = $signed({rx[31], rx}) - $signed({tx_ff[31], tx_ff});
   assign ddy = $signed({ry[31], ry}) - $signed({ty_ff[31], ty_ff});
   assign adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
   assign ady = ddy[32] ? 33'(-ddy) : 33'(ddy);
   assign d2  = 65'(adx * adx) + 65'(ady * ady);

   // steer deltas from nearest to target
   logic signed [32:0] sdx, sdy;
   assign sdx = $signed({tx_ff[31], tx_ff}) - $signed({nx_ff[31], nx_ff});
   assign sdy = $signed({ty_ff[31], ty_ff}) - $signed({ny_ff[31], ny_ff});
   logic [32:0] asx, asy;
   assign asx = sdx[32] ? 33'(-sdx) : 33'(sdx);
   assign asy = sdy[32] ? 33'(-sdy) : 33'(sdy);
   logic [61:0] stepsq;
   assign stepsq = 62'(step_ff * step_ff);
   // target lies within one step of the nearest node
   logic near;
   assign near = best_ff < {3'd0, stepsq};

   // restoring square root: trial value per step
   logic [36:0] trial;
   logic [36:0] rrem;
   assign rrem  = {rem_ff, rad_ff[69:68]};
   assign trial = {root_ff[34:0], 2'b01};

   // restoring divider step
   logic [35:0] dtry;
   logic        dfit;
   assign dtry = {drem_ff, num_ff[63]};
   assign dfit = dtry >= {1'b0, root_ff};

   function automatic logic [31:0] sat_add(input logic [31:0] b, input logic neg,
                                           input logic [63:0] q);
      logic signed [65:0] r;
      r = $signed({{34{b[31]}}, b}) + (neg ? -$signed({2'b0, q}) : $signed({2'b0, q}));
      if (r > 66'sd2147483647) return 32'h7fffffff;
      if (r < -66'sd2147483648) return 32'h80000000;
      return r[31:0];
   endfunction

   always_comb begin
      we = 1'b0;
      waddr = '0;
      wx = req_tdata[31:0];
      wy = req_tdata[63:32];
      wp = req_tdata[74:64];
      raddr = scan_ff[AW-1:0];
      if (acc && req_tuser == rrt_pkg::REQ_PLANT) begin
         we = 1'b1;
         wp = '0;
      end else if (acc && req_tuser == rrt_pkg::REQ_APPEND
                   && 32'(count_ff) < 32'(limit_ff) && 32'(count_ff) < TABLE_DEPTH) begin
         we = 1'b1;
         waddr = count_ff[AW-1:0];
      end
      if (state_ff == S_PICK) raddr = bidx_ff;
   end

   // result valid: set when a transaction finishes, cleared when taken
   logic fin;
   assign fin = (state_ff == S_IDLE && acc
                 && !(req_tuser == rrt_pkg::REQ_EXTEND && count_ff != '0))
                || (state_ff == S_PDATA && near) || state_ff == S_OUT;
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (fin) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         step_ff   <= rrt_pkg::STEP_RESET;
         limit_ff  <= rrt_pkg::LIMIT_RESET;
         rdv_ff    <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[2])
               rrt_pkg::REG_STEP: step_ff  <= csr_pwdata[30:0];
               default:           limit_ff <= csr_pwdata[11:0];
            endcase
         end
         case (state_ff)
            S_IDLE: if (acc) begin
               oidx_ff <= '0;
               osx_ff  <= '0;
               osy_ff  <= '0;
               ost_ff  <= rrt_pkg::ST_OK;
               tx_ff   <= req_tdata[31:0];
               ty_ff   <= req_tdata[63:32];
               case (req_tuser)
                  rrt_pkg::REQ_PLANT: begin
                     count_ff <= CW'(1);
                  end
                  rrt_pkg::REQ_EXTEND: begin
                     if (count_ff == '0) begin
                        ost_ff <= rrt_pkg::ST_EMPTY;
                     end else begin
                        scan_ff  <= '0;
                        rdv_ff   <= 1'b0;
                        state_ff <= S_SCAN;
                     end
                  end
                  rrt_pkg::REQ_APPEND: begin
                     if (we) begin
                        oidx_ff  <= 11'(count_ff);
                        count_ff <= count_ff + CW'(1);
                     end else begin
                        ost_ff <= rrt_pkg::ST_FULL;
                     end
                  end
                  default: ;
               endcase
            end
            S_SCAN: begin
               rdv_ff <= scan_ff < count_ff;
               rdi_ff <= scan_ff[AW-1:0];
               if (scan_ff < count_ff) scan_ff <= scan_ff + CW'(1);
               if (rdv_ff && (rdi_ff == '0 || d2 < best_ff)) begin
                  best_ff <= d2;
                  bidx_ff <= rdi_ff;
               end
               if (rdv_ff && !(scan_ff < count_ff)) state_ff <= S_PICK;
            end
            S_PICK: state_ff <= S_PDATA;
            S_PDATA: begin
               nx_ff <= rx;
               ny_ff <= ry;
               oidx_ff <= 11'(bidx_ff);
               root_ff <= '0;
               rem_ff  <= '0;
               rad_ff  <= {5'd0, best_ff};
               it_ff   <= 6'd0;
               if (near) begin
                  osx_ff   <= tx_ff;
                  osy_ff   <= ty_ff;
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_SQR;
               end
            end
            S_SQR: begin
               rad_ff <= {rad_ff[67:0], 2'b00};
               if (rrem >= trial) begin
                  rem_ff  <= 35'(rrem - trial);
                  root_ff <= {root_ff[33:0], 1'b1};
               end else begin
                  rem_ff  <= 35'(rrem);
                  root_ff <= {root_ff[33:0], 1'b0};
               end
               if (it_ff == 6'd34) begin
                  it_ff    <= '0;
                  num_ff   <= 64'(step_ff) * 64'(asx);
                  drem_ff  <= '0;
                  state_ff <= S_DIVX;
               end else begin
                  it_ff <= it_ff + 6'd1;
               end
            end
            S_DIVX, S_DIVY: begin
               quo_ff <= {quo_ff[62:0], dfit};
               if (it_ff == 6'd63) begin
                  it_ff    <= '0;
                  drem_ff  <= '0;
                  num_ff   <= 64'(step_ff) * 64'(asy);
                  state_ff <= (state_ff == S_DIVX) ? S_DIVY : S_OUT;
               end else begin
                  it_ff   <= it_ff + 6'd1;
                  num_ff  <= {num_ff[62:0], 1'b0};
                  drem_ff <= dfit ? 35'(dtry - {1'b0, root_ff}) : 35'(dtry);
               end
               if (state_ff == S_DIVX && it_ff == 6'd63) begin
                  osx_ff <= (root_ff == '0) ? nx_ff
                     : sat_add(nx_ff, sdx[32], {quo_ff[62:0], dfit});
               end
            end
            S_OUT: begin
               osy_ff   <= (root_ff == '0) ? ny_ff : sat_add(ny_ff, sdy[32], quo_ff);
               state_ff <= S_WAIT;
            end
            S_WAIT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // results never pile up: accept needs an empty or draining output
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && !rsp_tready |=> ovalid_ff) else $error("result lost");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_DEPTH) else $error("count beyond depth");
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("accept while busy");
endmodule

>>> bench/tb.sv
// self-checking testbench for the rrt nearest-node and steer block
module tb;
   typedef struct packed {
      logic [10:0] idx;
      logic [31:0] sx;
      logic [31:0] sy;
      logic [1:0]  st;
   } steer_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rrt_nearest_and_steer dut (.*);

   // 20 unit period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // own copy of the node table and the registers
   logic signed [31:0] tree_x [2048];
   logic signed [31:0] tree_y [2048];
   int                 tree_count = 0;
   logic [30:0]        cfg_step = rrt_pkg::STEP_RESET;
   logic [11:0]        cfg_limit = rrt_pkg::LIMIT_RESET;

   steer_rsp_type pending_rsp [$];
   int         mismatches = 0;
   int         items_sent = 0;
   bit         idle_on = 1'b1;
   bit         hold_rsp = 1'b0;

   // exact squared distance, 66 bits
   function automatic logic [65:0] sq_dist(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] bx, logic signed [31:0] by);
      logic signed [33:0] dx, dy;
      logic [65:0] mx, my;
      dx = 34'(ax) - 34'(bx);
      dy = 34'(ay) - 34'(by);
      mx = dx[33] ? 66'(-dx) : 66'(dx);
      my = dy[33] ? 66'(-dy) : 66'(dy);
      return mx * mx + my * my;
   endfunction

   // one steered coordinate with saturation
   function automatic logic [31:0] steer_axis(logic signed [31:0] base, logic signed [33:0] d,
                                              logic [127:0] span);
      logic [127:0] m, q;
      longint r;
      if (span == 0) return base;
      m = d[33] ? 128'(-d) : 128'(d);
      q = (128'(cfg_step) * m) / span;
      r = d[33] ? longint'(base) - longint'(q) : longint'(base) + longint'(q);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // expected result of one request, updating the table
   function automatic steer_rsp_type predict_steer(logic [1:0] kind, logic signed [31:0] px,
                                                   logic signed [31:0] py);
      steer_rsp_type r;
      logic [65:0] best_d, d;
      logic [127:0] lo, hi, mid;
      int best;
      r = '0;
      case (kind)
         rrt_pkg::REQ_PLANT: begin
            tree_x[0] = px;
            tree_y[0] = py;
            tree_count = 1;
         end
         rrt_pkg::REQ_EXTEND: begin
            if (tree_count == 0) begin
               r.st = rrt_pkg::ST_EMPTY;
            end else begin
               best = 0;
               best_d = sq_dist(tree_x[0], tree_y[0], px, py);
               for (int i = 1; i < tree_count; i++) begin
                  d = sq_dist(tree_x[i], tree_y[i], px, py);
                  if (d < best_d) begin
                     best_d = d;
                     best = i;
                  end
               end
               r.idx = best[10:0];
               if (128'(best_d) < 128'(cfg_step) * 128'(cfg_step)) begin
                  r.sx = px;
                  r.sy = py;
               end else begin
                  // floor of the root by bisection
                  lo = 0;
                  hi = 128'd1 << 34;
                  while (hi - lo > 1) begin
                     mid = lo + (hi - lo) / 2;
                     if (128'(best_d) < mid * mid) hi = mid;
                     else lo = mid;
                  end
                  r.sx = steer_axis(tree_x[best], 34'(px) - 34'(tree_x[best]), lo);
                  r.sy = steer_axis(tree_y[best], 34'(py) - 34'(tree_y[best]), lo);
               end
            end
         end
         rrt_pkg::REQ_APPEND: begin
            if (tree_count >= cfg_limit || tree_count >= 2048) begin
               r.st = rrt_pkg::ST_FULL;
            end else begin
               tree_x[tree_count] = px;
               tree_y[tree_count] = py;
               r.idx = tree_count[10:0];
               tree_count++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // one request transaction; valid stays high across back-to-back sends
   task automatic send_req(logic [1:0] kind, logic [31:0] px, logic [31:0] py,
                           logic [10:0] parent);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, parent, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.insert(pending_rsp.size(), predict_steer(kind, px, py));
      items_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write, only while idle
   task automatic write_reg(logic [0:0] which, logic [31:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (which == rrt_pkg::REG_STEP) cfg_step = value[30:0];
      else cfg_limit = value[11:0];
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   function automatic logic [31:0] rand_step;
      case ($urandom_range(0, 4))
         0:       return 32'd1;
         1:       return 32'h7fff_ffff;
         2:       return $urandom_range(1, 8) << 16;
         3:       return $urandom_range(1, 32'h7fff_ffff);
         default: return $urandom_range(1, 40000);
      endcase
   endfunction

   // result side: compare each transaction with the oldest expectation
   always @(posedge clock) begin
      steer_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[10:0], rsp_tdata[42:11], rsp_tdata[74:43], rsp_tuser};
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("tb: unexpected result %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.idx !== want.idx || got.sx !== want.sx || got.sy !== want.sy ||
                got.st !== want.st) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: mismatch idx %0d/%0d x %h/%h y %h/%h st %0d/%0d",
                           want.idx, got.idx, want.sx, got.sx, want.sy, got.sy,
                           want.st, got.st);
            end
         end
      end
   end

   // receiver stalls: random bursts or one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // empty tree, unknown kind, append into an empty tree
   task automatic test_empty_tree;
      send_req(rrt_pkg::REQ_EXTEND, 32'h7fff_ffff, 32'h8000_0000, 11'd0);
      send_req(rrt_pkg::REQ_UNKNOWN, $urandom, $urandom, 11'h7ff);
      send_req(rrt_pkg::REQ_APPEND, 32'h0001_0000, 32'hffff_0000, 11'h7ff);
      send_req(rrt_pkg::REQ_EXTEND, 32'h0000_0000, 32'h0000_0000, 11'd0);
   endtask

   // extremes, ties, near and far targets
   task automatic test_directed;
      write_reg(rrt_pkg::REG_STEP, 32'h7fff_ffff);
      write_reg(rrt_pkg::REG_LIMIT, 32'd2048);
      send_req(rrt_pkg::REQ_PLANT, 32'h8000_0000, 32'h8000_0000, 11'h7ff);
      send_req(rrt_pkg::REQ_EXTEND, 32'h7fff_ffff, 32'h7fff_ffff, 11'd0);
      send_req(rrt_pkg::REQ_APPEND, 32'h7fff_ffff, 32'h8000_0000, 11'h7ff);
      send_req(rrt_pkg::REQ_APPEND, 32'h8000_0000, 32'h7fff_ffff, 11'd0);
      send_req(rrt_pkg::REQ_EXTEND, 32'h0000_0000, 32'h0000_0000, 11'd0);
      write_reg(rrt_pkg::REG_STEP, 32'd1);
      send_req(rrt_pkg::REQ_EXTEND, 32'h7fff_ffff, 32'h0000_0000, 11'd0);
      send_req(rrt_pkg::REQ_EXTEND, 32'h8000_0000, 32'h8000_0000, 11'd0);
      // two nodes at equal distance, lowest index wins
      send_req(rrt_pkg::REQ_PLANT, 32'h0001_0000, 32'h0000_0000, 11'd0);
      send_req(rrt_pkg::REQ_APPEND, 32'hffff_0000, 32'h0000_0000, 11'd0);
      send_req(rrt_pkg::REQ_EXTEND, 32'h0000_0000, 32'h0005_0000, 11'd0);
      write_reg(rrt_pkg::REG_STEP, 32'h0001_0000);
      send_req(rrt_pkg::REQ_EXTEND, 32'h0001_8000, 32'h0000_0000, 11'd0);
   endtask

   // full table, and the limit lowered below the count
   task automatic test_full_table;
      write_reg(rrt_pkg::REG_LIMIT, 32'd1);
      send_req(rrt_pkg::REQ_PLANT, 32'h0002_0000, 32'h0003_0000, 11'd0);
      send_req(rrt_pkg::REQ_APPEND, 32'h0004_0000, 32'h0003_0000, 11'd0);
      write_reg(rrt_pkg::REG_LIMIT, 32'd4);
      repeat (4) send_req(rrt_pkg::REQ_APPEND, rand_coord(1), rand_coord(1),
                          11'($urandom_range(0, 2047)));
      write_reg(rrt_pkg::REG_LIMIT, 32'd2);
      send_req(rrt_pkg::REQ_APPEND, 32'h0000_0000, 32'h0000_0000, 11'd5);
      send_req(rrt_pkg::REQ_EXTEND, 32'h0009_0000, 32'h0009_0000, 11'd0);
   endtask

   // long receiver hold-off with the sender still pushing, then a full pause
   task automatic test_backpressure;
      write_reg(rrt_pkg::REG_LIMIT, 32'd16);
      send_req(rrt_pkg::REQ_PLANT, rand_coord(1), rand_coord(1), 11'd0);
      hold_rsp = 1'b1;
      repeat (8) send_req(rrt_pkg::REQ_APPEND, rand_coord(2), rand_coord(2),
                          11'($urandom_range(0, 2047)));
      repeat (4) send_req(rrt_pkg::REQ_EXTEND, rand_coord(2), rand_coord(2), 11'd0);
      drain();
   endtask

   // random trees: configure, usually plant, then grow and query, with some noise
   task automatic test_random_trees(int quota);
      int mode, n;
      logic [1:0] kind;
      while (items_sent < quota) begin
         write_reg(rrt_pkg::REG_STEP, rand_step());
         write_reg(rrt_pkg::REG_LIMIT,
                   $urandom_range(0, 9) == 0 ? 32'd2048 : $urandom_range(1, 40));
         if (items_sent > quota - 40) idle_on = 1'b0;
         mode = $urandom_range(0, 2);
         if ($urandom_range(0, 7) != 0)
            send_req(rrt_pkg::REQ_PLANT, rand_coord(mode), rand_coord(mode),
                     11'($urandom_range(0, 2047)));
         n = $urandom_range(4, 30);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0:       kind = 2'($urandom_range(0, 3));
               1, 2, 3, 4: kind = rrt_pkg::REQ_APPEND;
               default: kind = rrt_pkg::REQ_EXTEND;
            endcase
            send_req(kind, rand_coord(mode), rand_coord(mode), 11'($urandom_range(0, 2047)));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tree();
      test_directed();
      test_full_table();
      test_backpressure();
      test_random_trees(265);
      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #60000000;
      $display("tb: done, errors");
      $finish;
   end
endmodule
